[hdl/twcr_pkg.sv]
// Shared types, constants and helpers of the textured wall column rasterizer.
// Used by every module under hdl; depends on nothing else.
package twcr_pkg;

  // Screen and fixed-point geometry.
  localparam int SCREEN_HEIGHT = 512;
  localparam int FRACTION_BITS = 16;
  localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

  // Field widths.
  localparam int COL_W    = 12;
  localparam int HEIGHT_W = 16;
  localparam int FRAC_W   = 16;
  localparam int TEX_W    = 13;
  localparam int TCOL_W   = 12;
  localparam int ROW_W    = $clog2(SCREEN_HEIGHT + 1);
  localparam int SPAN_W   = HEIGHT_W + 1;
  localparam int STEP_W   = 28;
  localparam int ACC_W    = 32;
  localparam int QUO_W    = TEX_W + FRACTION_BITS;
  localparam int CNT_W    = $clog2(QUO_W);
  localparam int HD_W     = HEIGHT_W - 1;
  localparam int PROD_W   = HD_W + STEP_W;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 4;

  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
  localparam logic [TEX_W-1:0]  TEX_MAX  = TEX_W'(4096);
  localparam logic [TEX_W-1:0]  TEX_RESET = TEX_W'(64);

  // Pixel kinds.
  localparam logic [1:0] KIND_CEILING   = 2'd0;
  localparam logic [1:0] KIND_FLOOR     = 2'd1;
  localparam logic [1:0] KIND_WALL      = 2'd2;
  localparam logic [1:0] KIND_UNCHANGED = 2'd3;

  // Input operations.
  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Wall sides below this code take their texture column from the y fraction.
  localparam logic [1:0] SIDE_SOUTH = 2'd2;

  typedef logic [NUM_REGS-1:0][TEX_W-1:0] tex_regs_t;

  // Front sequencer states.
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_MUL,
    FR_PUSH
  } front_state_t;

  // One command between front and back: a row tick or a finished column setup.
  typedef struct packed {
    logic               is_setup;
    logic [COL_W-1:0]   column;
    logic [1:0]         side;
    logic [TCOL_W-1:0]  tcol;
    logic [ROW_W-1:0]   top;
    logic [SPAN_W-1:0]  bottom;
    logic [SPAN_W-1:0]  wend;
    logic [STEP_W-1:0]  step;
    logic [ACC_W-1:0]   acc;
  } cmd_t;

  // Texture size register as used: zero acts as one, oversize as the maximum.
  function automatic logic [TEX_W-1:0] tex_size(input logic [TEX_W-1:0] v);
    logic [TEX_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = TEX_W'(1);
    end else if (v > TEX_MAX) begin
      r = TEX_MAX;
    end
    return r;
  endfunction

  // Clamp the raw quotient to the step width.
  function automatic logic [STEP_W-1:0] sat_step(input logic [QUO_W-1:0] q);
    logic [QUO_W+STEP_W-1:0] wide;
    logic [STEP_W-1:0]       r;
    wide = (QUO_W + STEP_W)'(q);
    r = wide[STEP_W-1:0];
    if (wide > (QUO_W + STEP_W)'(STEP_MAX)) begin
      r = STEP_MAX;
    end
    return r;
  endfunction

  // Clamp the start accumulator product to the accumulator width.
  function automatic logic [ACC_W-1:0] sat_acc(input logic [PROD_W-1:0] p);
    logic [PROD_W+ACC_W-1:0] wide;
    logic [ACC_W-1:0]        r;
    wide = (PROD_W + ACC_W)'(p);
    r = wide[ACC_W-1:0];
    if (wide > (PROD_W + ACC_W)'(ACC_MAX)) begin
      r = ACC_MAX;
    end
    return r;
  endfunction

endpackage

[hdl/twcr_queue.sv]
// Four-entry command queue between the front and the back of the rasterizer.
// Depends on twcr_pkg for the command type.
module twcr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  twcr_pkg::cmd_t wr_data,
  output logic          q_full,
  input  logic          rd_en,
  output twcr_pkg::cmd_t rd_data,
  output logic          q_empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  twcr_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign q_full  = (count == (PTR_W + 1)'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

[hdl/twcr_front.sv]
// Front of the rasterizer: accepts items, passes row ticks on and turns a column
// setup into a ready-made command (serial divider, then the start accumulator multiply). Uses twcr_pkg.
module twcr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  twcr_pkg::tex_regs_t         tex_regs,
  input  logic                        push,
  output logic                        full,
  input  logic                        op,
  input  logic [twcr_pkg::COL_W-1:0]  screen_column,
  input  logic [twcr_pkg::HEIGHT_W-1:0] wall_height,
  input  logic [1:0]                  wall_side,
  input  logic [twcr_pkg::FRAC_W-1:0] hit_x_frac,
  input  logic [twcr_pkg::FRAC_W-1:0] hit_y_frac,
  input  logic                        q_full,
  output logic                        q_push,
  output twcr_pkg::cmd_t              q_data
);

  twcr_pkg::front_state_t state, state_next;

  logic [twcr_pkg::HEIGHT_W-1:0] h;
  logic [twcr_pkg::HD_W-1:0]     hd;
  logic [twcr_pkg::COL_W-1:0]    column;
  logic [1:0]                    side;
  logic [twcr_pkg::TCOL_W-1:0]   tcol;
  logic [twcr_pkg::ROW_W-1:0]    top;
  logic [twcr_pkg::SPAN_W-1:0]   bottom;
  logic [twcr_pkg::SPAN_W-1:0]   wend;
  logic [twcr_pkg::QUO_W-1:0]    quo;
  logic [twcr_pkg::HEIGHT_W-1:0] rem;
  logic [twcr_pkg::CNT_W-1:0]    cnt;
  logic [twcr_pkg::STEP_W-1:0]   step;
  logic [twcr_pkg::PROD_W-1:0]   acc_prod;

  logic                          take;
  logic [twcr_pkg::HEIGHT_W-1:0] h_in;
  logic [twcr_pkg::HEIGHT_W:0]   up_in;
  logic [twcr_pkg::ROW_W-1:0]    top_in;
  logic [twcr_pkg::TEX_W-1:0]    tw_in;
  logic [twcr_pkg::TEX_W-1:0]    th_in;
  logic [twcr_pkg::FRAC_W-1:0]   frac_in;
  logic [twcr_pkg::FRAC_W+twcr_pkg::TEX_W-1:0] tcol_prod;
  logic [twcr_pkg::SPAN_W-1:0]   rem_sh;
  logic                          qbit;
  logic [twcr_pkg::SPAN_W-1:0]   rem_sub;
  logic [twcr_pkg::STEP_W-1:0]   step_sat;

  assign take = push && !full;

  // Setup geometry from the incoming item; a zero height counts as one.
  always_comb begin
    h_in    = (wall_height == '0) ? twcr_pkg::HEIGHT_W'(1) : wall_height;
    up_in   = ((twcr_pkg::HEIGHT_W + 1)'(h_in) + (twcr_pkg::HEIGHT_W + 1)'(1)) >> 1;
    top_in  = '0;
    if (up_in < (twcr_pkg::HEIGHT_W + 1)'(twcr_pkg::HALF_HEIGHT)) begin
      top_in = twcr_pkg::ROW_W'((twcr_pkg::HEIGHT_W + 1)'(twcr_pkg::HALF_HEIGHT) - up_in);
    end
    tw_in   = twcr_pkg::tex_size(tex_regs[{wall_side, 1'b0}]);
    th_in   = twcr_pkg::tex_size(tex_regs[{wall_side, 1'b1}]);
    frac_in = (wall_side < twcr_pkg::SIDE_SOUTH) ? hit_y_frac : hit_x_frac;
    tcol_prod = (twcr_pkg::FRAC_W + twcr_pkg::TEX_W)'(frac_in) *
                (twcr_pkg::FRAC_W + twcr_pkg::TEX_W)'(tw_in);
  end

  // One restoring divider step per cycle.
  always_comb begin
    rem_sh  = {rem, quo[twcr_pkg::QUO_W-1]};
    qbit    = (rem_sh >= twcr_pkg::SPAN_W'(h));
    rem_sub = qbit ? (rem_sh - twcr_pkg::SPAN_W'(h)) : rem_sh;
    step_sat = twcr_pkg::sat_step(quo);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      twcr_pkg::FR_IDLE: begin
        if (take && (op == twcr_pkg::OP_SETUP)) begin
          state_next = twcr_pkg::FR_DIV;
        end
      end
      twcr_pkg::FR_DIV: begin
        if (cnt == '0) begin
          state_next = twcr_pkg::FR_MUL;
        end
      end
      twcr_pkg::FR_MUL: begin
        state_next = twcr_pkg::FR_PUSH;
      end
      twcr_pkg::FR_PUSH: begin
        if (!q_full) begin
          state_next = twcr_pkg::FR_IDLE;
        end
      end
      default: begin
        state_next = twcr_pkg::FR_IDLE;
      end
    endcase
  end

  // Outputs: handshake toward the source and the command toward the queue.
  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    q_data = '0;
    case (state)
      twcr_pkg::FR_IDLE: begin
        full   = q_full;
        q_push = push && !q_full && (op == twcr_pkg::OP_TICK);
      end
      twcr_pkg::FR_PUSH: begin
        q_push          = !q_full;
        q_data.is_setup = 1'b1;
        q_data.column   = column;
        q_data.side     = side;
        q_data.tcol     = tcol;
        q_data.top      = top;
        q_data.bottom   = bottom;
        q_data.wend     = wend;
        q_data.step     = step;
        q_data.acc      = twcr_pkg::sat_acc(acc_prod);
      end
      default: begin
        full = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twcr_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Setup working registers.
  always_ff @(posedge clk) begin
    if (state == twcr_pkg::FR_IDLE && take && op == twcr_pkg::OP_SETUP) begin
      h      <= h_in;
      hd     <= (h_in > twcr_pkg::HEIGHT_W'(twcr_pkg::SCREEN_HEIGHT)) ?
                twcr_pkg::HD_W'((h_in - twcr_pkg::HEIGHT_W'(twcr_pkg::SCREEN_HEIGHT)) >> 1) :
                '0;
      column <= screen_column;
      side   <= wall_side;
      tcol   <= tcol_prod[twcr_pkg::FRAC_W +: twcr_pkg::TCOL_W];
      top    <= top_in;
      bottom <= twcr_pkg::SPAN_W'(top_in) + twcr_pkg::SPAN_W'(h_in);
      wend   <= twcr_pkg::SPAN_W'(twcr_pkg::HALF_HEIGHT) + twcr_pkg::SPAN_W'(h_in >> 1);
      quo    <= {th_in, {twcr_pkg::FRACTION_BITS{1'b0}}};
      rem    <= '0;
      cnt    <= twcr_pkg::CNT_W'(twcr_pkg::QUO_W - 1);
    end else if (state == twcr_pkg::FR_DIV) begin
      quo <= {quo[twcr_pkg::QUO_W-2:0], qbit};
      rem <= rem_sub[twcr_pkg::HEIGHT_W-1:0];
      cnt <= cnt - twcr_pkg::CNT_W'(1);
    end else if (state == twcr_pkg::FR_MUL) begin
      step     <= step_sat;
      acc_prod <= twcr_pkg::PROD_W'(hd) * twcr_pkg::PROD_W'(step_sat);
    end
  end

endmodule

[hdl/twcr_back.sv]
// Back of the rasterizer: holds the column state, walks the rows and keeps
// one pixel register toward the result side. Uses twcr_pkg.
module twcr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  twcr_pkg::tex_regs_t        tex_regs,
  input  logic                       q_empty,
  input  twcr_pkg::cmd_t             q_data,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [twcr_pkg::COL_W-1:0] pixel_column,
  output logic [11:0]                pixel_row,
  output logic [1:0]                 pixel_kind,
  output logic [1:0]                 texture_select,
  output logic [twcr_pkg::TCOL_W-1:0] texel_column,
  output logic [11:0]                texel_row,
  output logic                       last_row
);

  // Column state.
  logic [twcr_pkg::COL_W-1:0]  cur_column;
  logic [twcr_pkg::ROW_W-1:0]  row_counter;
  logic [twcr_pkg::ROW_W-1:0]  top;
  logic [twcr_pkg::SPAN_W-1:0] bottom;
  logic [twcr_pkg::SPAN_W-1:0] wend;
  logic [twcr_pkg::STEP_W-1:0] step;
  logic [twcr_pkg::ACC_W-1:0]  acc;
  logic [1:0]                  sel;
  logic [twcr_pkg::TCOL_W-1:0] tcol;
  logic                        finished;
  logic                        out_valid;

  logic                        out_free;
  logic                        do_setup;
  logic                        do_tick;
  logic                        emit;
  logic                        in_wall;
  logic                        draw;
  logic [twcr_pkg::TEX_W-1:0]  th_cur;
  logic [twcr_pkg::ACC_W-1:0]  tex_row;
  logic [twcr_pkg::ACC_W:0]    acc_sum;
  logic [1:0]                  kind;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign q_pop    = !q_empty && (q_data.is_setup || out_free);
  assign do_setup = q_pop && q_data.is_setup;
  assign do_tick  = q_pop && !q_data.is_setup;
  assign emit     = do_tick && (row_counter < twcr_pkg::ROW_W'(twcr_pkg::SCREEN_HEIGHT));

  // Classify the current row and decide whether a texel is drawn.
  always_comb begin
    th_cur  = twcr_pkg::tex_size(tex_regs[{sel, 1'b1}]);
    tex_row = acc >> twcr_pkg::FRACTION_BITS;
    in_wall = !finished && (row_counter >= top);
    draw    = in_wall && (tex_row < twcr_pkg::ACC_W'(th_cur)) &&
              (twcr_pkg::SPAN_W'(row_counter) < wend);
    acc_sum = (twcr_pkg::ACC_W + 1)'(acc) + (twcr_pkg::ACC_W + 1)'(step);
    kind    = twcr_pkg::KIND_UNCHANGED;
    if (row_counter < top) begin
      kind = twcr_pkg::KIND_CEILING;
    end else if (twcr_pkg::SPAN_W'(row_counter) > bottom) begin
      kind = twcr_pkg::KIND_FLOOR;
    end
    if (draw) begin
      kind = twcr_pkg::KIND_WALL;
    end
  end

  // Column state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_column  <= '0;
      row_counter <= '0;
      top         <= '0;
      bottom      <= '0;
      wend        <= '0;
      step        <= '0;
      acc         <= '0;
      sel         <= '0;
      tcol        <= '0;
      finished    <= 1'b1;
    end else if (do_setup) begin
      cur_column  <= q_data.column;
      row_counter <= '0;
      top         <= q_data.top;
      bottom      <= q_data.bottom;
      wend        <= q_data.wend;
      step        <= q_data.step;
      acc         <= q_data.acc;
      sel         <= q_data.side;
      tcol        <= q_data.tcol;
      finished    <= 1'b0;
    end else if (emit) begin
      row_counter <= row_counter + twcr_pkg::ROW_W'(1);
      if (draw) begin
        acc <= acc_sum[twcr_pkg::ACC_W] ? twcr_pkg::ACC_MAX : acc_sum[twcr_pkg::ACC_W-1:0];
      end else if (in_wall) begin
        finished <= 1'b1;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_column   <= cur_column;
      pixel_row      <= 12'(row_counter);
      pixel_kind     <= kind;
      texture_select <= draw ? sel : 2'd0;
      texel_column   <= draw ? tcol : '0;
      texel_row      <= draw ? 12'(tex_row) : 12'd0;
      last_row       <= (row_counter == twcr_pkg::ROW_W'(twcr_pkg::SCREEN_HEIGHT - 1));
    end
  end

endmodule

[hdl/textured_wall_column_rasterizer.sv]
// Top level of the textured wall column rasterizer: configuration registers,
// front, command queue and back. Depends on twcr_pkg, twcr_front, twcr_queue, twcr_back.
//
//   channel   handshake             payload
//   input     push / full           op, screen_column, wall_height, wall_side,
//                                   hit_x_frac, hit_y_frac
//   result    empty / pop           pixel_column, pixel_row, pixel_kind,
//                                   texture_select, texel_column, texel_row, last_row
//   config    cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// Row ticks stream at one per clock while the result side keeps taking pixels.
// A column setup holds the input side through the front's divide, multiply and
// push states, paced by the one-bit-per-cycle step divider, and longer while the
// queue stays full; ticks already queued keep draining meanwhile. Reset is
// synchronous and needs no clearing pass. A stalled result side stops the back;
// the four-entry queue then fills and raises full.
module textured_wall_column_rasterizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            op,
  input  logic [twcr_pkg::COL_W-1:0]      screen_column,
  input  logic [twcr_pkg::HEIGHT_W-1:0]   wall_height,
  input  logic [1:0]                      wall_side,
  input  logic [twcr_pkg::FRAC_W-1:0]     hit_x_frac,
  input  logic [twcr_pkg::FRAC_W-1:0]     hit_y_frac,
  output logic                            empty,
  input  logic                            pop,
  output logic [twcr_pkg::COL_W-1:0]      pixel_column,
  output logic [11:0]                     pixel_row,
  output logic [1:0]                      pixel_kind,
  output logic [1:0]                      texture_select,
  output logic [twcr_pkg::TCOL_W-1:0]     texel_column,
  output logic [11:0]                     texel_row,
  output logic                            last_row,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [twcr_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [twcr_pkg::TEX_W-1:0]      cfg_data
);

  twcr_pkg::tex_regs_t tex_regs;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  twcr_pkg::cmd_t      q_wr;
  twcr_pkg::cmd_t      q_rd;

  assign cfg_ready = 1'b1;

  // Texture size registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_regs <= {twcr_pkg::NUM_REGS{twcr_pkg::TEX_RESET}};
    end else if (cfg_valid && cfg_index < twcr_pkg::REG_IDX_W'(twcr_pkg::NUM_REGS)) begin
      tex_regs[cfg_index[$clog2(twcr_pkg::NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  // Item intake and column setup.
  twcr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .tex_regs      (tex_regs),
    .push          (push),
    .full          (full),
    .op            (op),
    .screen_column (screen_column),
    .wall_height   (wall_height),
    .wall_side     (wall_side),
    .hit_x_frac    (hit_x_frac),
    .hit_y_frac    (hit_y_frac),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr)
  );

  // Command queue.
  twcr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .q_empty (q_empty)
  );

  // Row walk and pixel output.
  twcr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .tex_regs       (tex_regs),
    .q_empty        (q_empty),
    .q_data         (q_rd),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .pixel_column   (pixel_column),
    .pixel_row      (pixel_row),
    .pixel_kind     (pixel_kind),
    .texture_select (texture_select),
    .texel_column   (texel_column),
    .texel_row      (texel_row),
    .last_row       (last_row)
  );

endmodule

[tb/twcr_pixel_checker.sv]
// Pixel stream checker for the textured wall column rasterizer: predicts every
// pixel from the accepted requests and compares it with what the block delivers.
// Depends on twcr_pkg for field widths, screen geometry and pixel kind codes.
module twcr_pixel_checker
  import twcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic                 op,
  input  logic [COL_W-1:0]     screen_column,
  input  logic [HEIGHT_W-1:0]  wall_height,
  input  logic [1:0]           wall_side,
  input  logic [FRAC_W-1:0]    hit_x_frac,
  input  logic [FRAC_W-1:0]    hit_y_frac,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [COL_W-1:0]     pixel_column,
  input  logic [11:0]          pixel_row,
  input  logic [1:0]           pixel_kind,
  input  logic [1:0]           texture_select,
  input  logic [TCOL_W-1:0]    texel_column,
  input  logic [11:0]          texel_row,
  input  logic                 last_row,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [TEX_W-1:0]     cfg_data,
  output int                   failures,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Beyond this many reported mismatches only the count keeps growing.
  localparam int REPORT_LIMIT = 100;

  typedef struct {
    logic [COL_W-1:0]  column;
    logic [11:0]       row;
    logic [1:0]        kind;
    logic [1:0]        tsel;
    logic [TCOL_W-1:0] tcol;
    logic [11:0]       trow;
    logic              last;
  } pixel_t;

  // Texture sizes as last written, and the column currently being drawn.
  logic [TEX_W-1:0]  tex_reg [NUM_REGS];
  logic [COL_W-1:0]  col_now;
  logic [12:0]       row_next;
  logic [12:0]       top_row;
  logic [SPAN_W-1:0] bottom_row;
  logic [SPAN_W-1:0] end_row;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0]  acc;
  logic [1:0]        tex_sel;
  logic [TCOL_W-1:0] tex_col;
  logic              wall_done;

  pixel_t pixel_queue [$];
  int     reported;

  // A size register of zero behaves as one texel, oversize as the largest texture.
  function automatic int unsigned texture_dim(input logic [TEX_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > TEX_MAX) begin
      return TEX_MAX;
    end
    return raw;
  endfunction

  // Column setup: texture choice, texel column, vertical step and wall extent.
  task automatic start_column(input logic [COL_W-1:0] col, input logic [HEIGHT_W-1:0] height,
                              input logic [1:0] side, input logic [FRAC_W-1:0] x_frac,
                              input logic [FRAC_W-1:0] y_frac);
    int unsigned h;
    int unsigned up;
    int unsigned tw;
    int unsigned th;
    int unsigned frac;
    longint unsigned wide;
    longint unsigned span;
    h = (height == '0) ? 1 : height;
    up = (h + 1) / 2;
    tw = texture_dim(tex_reg[{side, 1'b0}]);
    th = texture_dim(tex_reg[{side, 1'b1}]);
    // East and west faces run along y, so the y fraction picks the column.
    frac = (side < SIDE_SOUTH) ? y_frac : x_frac;
    wide = frac;
    wide = (wide * tw) >> 16;
    tex_col = wide[TCOL_W-1:0];
    wide = th;
    wide = (wide << FRACTION_BITS) / h;
    if (wide > STEP_MAX) begin
      wide = STEP_MAX;
    end
    step = wide[STEP_W-1:0];
    top_row = (up < HALF_HEIGHT) ? 13'(HALF_HEIGHT - up) : '0;
    bottom_row = SPAN_W'(top_row + h);
    end_row = SPAN_W'(HALF_HEIGHT + h / 2);
    // A wall taller than the screen starts partway down its texture.
    span = 0;
    if (h > SCREEN_HEIGHT) begin
      span = (h - SCREEN_HEIGHT) / 2;
      span = span * wide;
      if (span > ACC_MAX) begin
        span = ACC_MAX;
      end
    end
    acc = span[ACC_W-1:0];
    col_now = col;
    tex_sel = side;
    row_next = '0;
    wall_done = 1'b0;
  endtask

  // Row tick: one pixel per row until the bottom of the screen, then nothing.
  task automatic advance_row(output bit produced, output pixel_t px);
    int unsigned j;
    longint unsigned r;
    longint unsigned sum;
    produced = 1'b0;
    px = '{default: '0};
    j = row_next;
    if (j >= SCREEN_HEIGHT) begin
      return;
    end
    px.kind = KIND_UNCHANGED;
    if (j < top_row) begin
      px.kind = KIND_CEILING;
    end else if (j > bottom_row) begin
      px.kind = KIND_FLOOR;
    end
    // Texels run from the top row until the texture or the lower half runs out.
    if (!wall_done && j >= top_row) begin
      r = acc >> FRACTION_BITS;
      if (r < texture_dim(tex_reg[{tex_sel, 1'b1}]) && j < end_row) begin
        px.kind = KIND_WALL;
        px.tsel = tex_sel;
        px.tcol = tex_col;
        px.trow = r[11:0];
        sum = acc;
        sum = sum + step;
        if (sum > ACC_MAX) begin
          sum = ACC_MAX;
        end
        acc = sum[ACC_W-1:0];
      end else begin
        wall_done = 1'b1;
      end
    end
    px.column = col_now;
    px.row = j[11:0];
    px.last = (j == SCREEN_HEIGHT - 1);
    row_next = 13'(j + 1);
    produced = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [11:0] row,
                             input logic [11:0] want, input logic [11:0] got);
    if (got !== want) begin
      failures++;
      if (reported < REPORT_LIMIT) begin
        reported++;
        $display("%0t: %s mismatch at row %0d, expected %0d, got %0d",
                 $time, name, row, want, got);
      end
    end
  endtask

  // Requests are taken after results at the same edge: a pixel never leaves
  // in the cycle its tick arrives.
  always @(posedge clk) begin : watch
    pixel_t want;
    pixel_t fresh;
    bit     produced;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        tex_reg[i] = TEX_RESET;
      end
      col_now = '0;
      row_next = '0;
      top_row = '0;
      bottom_row = '0;
      end_row = '0;
      step = '0;
      acc = '0;
      tex_sel = '0;
      tex_col = '0;
      wall_done = 1'b1;
      failures = 0;
      reported = 0;
      pixel_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) begin
        tex_reg[cfg_index[2:0]] = cfg_data;
      end
      if (pop && !empty) begin
        if (pixel_queue.size() == 0) begin
          failures++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("%0t: unexpected pixel, expected none, got column %0d row %0d kind %0d",
                     $time, pixel_column, pixel_row, pixel_kind);
          end
        end else begin
          want = pixel_queue.pop_front();
          check_field("pixel_column", want.row, want.column, pixel_column);
          check_field("pixel_row", want.row, want.row, pixel_row);
          check_field("pixel_kind", want.row, 12'(want.kind), 12'(pixel_kind));
          check_field("texture_select", want.row, 12'(want.tsel), 12'(texture_select));
          check_field("texel_column", want.row, want.tcol, texel_column);
          check_field("texel_row", want.row, want.trow, texel_row);
          check_field("last_row", want.row, 12'(want.last), 12'(last_row));
        end
      end
      if (push && !full) begin
        if (op == OP_SETUP) begin
          start_column(screen_column, wall_height, wall_side, hit_x_frac, hit_y_frac);
        end else begin
          advance_row(produced, fresh);
          if (produced) begin
            pixel_queue.push_back(fresh);
          end
        end
      end
    end
    outstanding <= pixel_queue.size();
  end

endmodule

[tb/textured_wall_column_rasterizer_tb.sv]
// Top of the textured wall column rasterizer testbench: clock, reset, column
// and row tick requests, texture size programming and the final verdict.
// Depends on twcr_pkg, the rasterizer RTL and twcr_pixel_checker.
module textured_wall_column_rasterizer_tb;
  import twcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] SIDE_EAST  = 2'd0;
  localparam logic [1:0] SIDE_WEST  = 2'd1;
  localparam logic [1:0] SIDE_NORTH = 2'd3;
  localparam int PHASE_ITEMS   = 350;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 48;

  typedef enum {
    TEX_ALL_MAX,
    TEX_ALL_MIN,
    TEX_OUT_OF_RANGE,
    TEX_RANDOM,
    TEX_MIXED
  } tex_style_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic                 op;
  logic [COL_W-1:0]     screen_column;
  logic [HEIGHT_W-1:0]  wall_height;
  logic [1:0]           wall_side;
  logic [FRAC_W-1:0]    hit_x_frac;
  logic [FRAC_W-1:0]    hit_y_frac;
  logic                 empty;
  logic                 pop;
  logic [COL_W-1:0]     pixel_column;
  logic [11:0]          pixel_row;
  logic [1:0]           pixel_kind;
  logic [1:0]           texture_select;
  logic [TCOL_W-1:0]    texel_column;
  logic [11:0]          texel_row;
  logic                 last_row;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [TEX_W-1:0]     cfg_data;

  int failures;
  int outstanding;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_requests;
  int hold_served;

  textured_wall_column_rasterizer uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .screen_column(screen_column), .wall_height(wall_height), .wall_side(wall_side),
    .hit_x_frac(hit_x_frac), .hit_y_frac(hit_y_frac), .empty(empty), .pop(pop),
    .pixel_column(pixel_column), .pixel_row(pixel_row), .pixel_kind(pixel_kind),
    .texture_select(texture_select), .texel_column(texel_column), .texel_row(texel_row),
    .last_row(last_row), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  twcr_pixel_checker pixel_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .screen_column(screen_column), .wall_height(wall_height), .wall_side(wall_side),
    .hit_x_frac(hit_x_frac), .hit_y_frac(hit_y_frac), .empty(empty), .pop(pop),
    .pixel_column(pixel_column), .pixel_row(pixel_row), .pixel_kind(pixel_kind),
    .texture_select(texture_select), .texel_column(texel_column), .texel_row(texel_row),
    .last_row(last_row), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .failures(failures),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("textured_wall_column_rasterizer_tb NOT OK");
    $finish;
  end

  // Pixel receiver: random stalls, plus one long hold-off per request so the
  // internal queue fills and the input side sees full.
  initial begin
    pop = 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_item(input logic item_op, input logic [COL_W-1:0] col,
                           input logic [HEIGHT_W-1:0] height, input logic [1:0] side,
                           input logic [FRAC_W-1:0] x_frac, input logic [FRAC_W-1:0] y_frac);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= item_op;
    screen_column <= col;
    wall_height <= height;
    wall_side <= side;
    hit_x_frac <= x_frac;
    hit_y_frac <= y_frac;
    do @(posedge clk); while (full);
  endtask

  task automatic write_tex_reg(input int unsigned index, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IDX_W'(index);
    cfg_data <= TEX_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program all eight texture sizes in one of several patterns.
  task automatic load_textures(input tex_style_t style);
    int unsigned value;
    // Indexes past the register file should be ignored.
    if (style == TEX_RANDOM) begin
      write_tex_reg(NUM_REGS + $urandom_range(0, 7), $urandom);
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      case (style)
        TEX_ALL_MAX: value = TEX_MAX;
        TEX_ALL_MIN: value = 1;
        TEX_OUT_OF_RANGE: begin
          if (i % 2 == 0) begin
            value = 0;
          end else begin
            value = (i == 1) ? 8191 : $urandom_range(4097, 8191);
          end
        end
        TEX_RANDOM: value = $urandom_range(1, 4096);
        default: begin
          case ($urandom_range(0, 5))
            0: value = 1;
            1: value = 2;
            2: value = 64;
            3: value = 4095;
            4: value = 4096;
            default: value = $urandom_range(1, 4096);
          endcase
        end
      endcase
      write_tex_reg(i, value);
    end
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, let every expected pixel arrive and any setup finish.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a setup followed by a run of row ticks; a few bursts of random requests.
  task automatic run_columns(input int unsigned items);
    int unsigned sent;
    int unsigned ticks;
    logic [HEIGHT_W-1:0] height;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(1'($urandom), 12'($urandom), 16'($urandom), 2'($urandom),
                    16'($urandom), 16'($urandom));
          sent++;
        end
      end else begin
        case ($urandom_range(0, 4))
          0: height = 16'($urandom_range(0, 3));
          1: height = 16'($urandom_range(4, 520));
          2: height = 16'($urandom_range(480, 1200));
          3: height = 16'($urandom_range(1200, 8000));
          default: height = 16'($urandom);
        endcase
        send_item(OP_SETUP, 12'($urandom), height, 2'($urandom), 16'($urandom),
                  16'($urandom));
        sent++;
        // A full column now and then reaches the floor, the last row and beyond.
        ticks = ($urandom_range(0, 99) < 25) ? SCREEN_HEIGHT + $urandom_range(0, 3)
                                             : $urandom_range(0, 24);
        repeat (ticks) begin
          send_item(OP_TICK, 12'($urandom), 16'($urandom), 2'($urandom),
                    16'($urandom), 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    op = OP_SETUP;
    screen_column = '0;
    wall_height = '0;
    wall_side = SIDE_EAST;
    hit_x_frac = '0;
    hit_y_frac = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_requests = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: ticks before any setup, then the height extremes on every face.
    repeat (2) send_item(OP_TICK, '0, '0, SIDE_EAST, '0, '0);
    send_item(OP_SETUP, 12'hFFF, 16'hFFFF, SIDE_NORTH, 16'hFFFF, 16'h0000);
    repeat (3) send_item(OP_TICK, '0, '0, SIDE_EAST, '0, '0);
    send_item(OP_SETUP, 12'h000, 16'h0000, SIDE_EAST, 16'h0000, 16'hFFFF);
    repeat (2) send_item(OP_TICK, '0, '0, SIDE_EAST, '0, '0);
    send_item(OP_SETUP, 12'hAAA, 16'd512, SIDE_WEST, 16'h1234, 16'h8000);
    repeat (3) send_item(OP_TICK, '0, '0, SIDE_EAST, '0, '0);
    send_item(OP_SETUP, 12'h555, 16'd1000, SIDE_SOUTH, 16'hFFFF, 16'h0001);
    repeat (3) send_item(OP_TICK, '0, '0, SIDE_EAST, '0, '0);
    send_item(OP_SETUP, 12'h7FF, 16'd513, SIDE_NORTH, 16'h8000, 16'hFFFF);
    repeat (2) send_item(OP_TICK, '0, '0, SIDE_EAST, '0, '0);
    settle();

    // Largest textures, no idling on either side.
    load_textures(TEX_ALL_MAX);
    run_columns(PHASE_ITEMS);
    settle();

    // Smallest textures, sender mostly idle.
    tx_idle_pct = 77;
    load_textures(TEX_ALL_MIN);
    run_columns(PHASE_ITEMS);
    settle();

    // Out-of-range sizes, receiver mostly stalled.
    tx_idle_pct = 0;
    rx_stall_pct = 77;
    load_textures(TEX_OUT_OF_RANGE);
    run_columns(PHASE_ITEMS);
    settle();

    // Random sizes, light idling on both sides.
    tx_idle_pct = 15;
    rx_stall_pct = 15;
    load_textures(TEX_RANDOM);
    run_columns(PHASE_ITEMS);
    settle();

    // Mixed sizes, receiver holds off while the sender keeps offering.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    load_textures(TEX_MIXED);
    hold_requests++;
    run_columns(PHASE_ITEMS);
    settle();

    if (failures == 0 && outstanding == 0) begin
      $display("textured_wall_column_rasterizer_tb OK");
    end else begin
      $display("textured_wall_column_rasterizer_tb NOT OK");
    end
    $finish;
  end

endmodule
